/* src/stepper_trapezoid_step_timer_defines.svh */
// assertion macros for the stepper step timer
`ifndef STEPPER_TRAPEZOID_STEP_TIMER_DEFINES_SVH
`define STEPPER_TRAPEZOID_STEP_TIMER_DEFINES_SVH
`ifndef SYNTHESIS
`define STT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define STT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define STT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define STT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* src/stt_pkg.sv */
// shared constants and types of the stepper step timer
package stt_pkg;
   localparam int TIMER_CLOCK_HZ = 1193180;
   localparam logic [13:0] MAX_STEPS = 14'd8192;
   localparam logic [13:0] RAMP_DEPTH = 14'd4096;
   localparam int RAMP_AW = 12;
   localparam logic [28:0] TIMER_DIVIDEND = 29'(TIMER_CLOCK_HZ * 256);
   localparam logic [15:0] PERIOD_MAX = 16'hFFFF;

   localparam logic [1:0] PH_ACCEL = 2'd0;
   localparam logic [1:0] PH_CRUISE = 2'd1;
   localparam logic [1:0] PH_DECEL = 2'd2;

   localparam logic [2:0] CSR_STEP_COUNT = 3'd0;
   localparam logic [2:0] CSR_INIT_SPEED = 3'd1;
   localparam logic [2:0] CSR_FINAL_SPEED = 3'd2;
   localparam logic [2:0] CSR_ACCEL = 3'd3;
   localparam logic [2:0] CSR_ROTATION = 3'd4;

   typedef struct packed {
      logic        start;
      logic        use_sqrt;
      logic [47:0] sq;
      logic [23:0] speed;
   } period_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] period;
      logic        sat;
   } period_res_type;
endpackage

/* src/stt_period.sv */
// iterative square root and division giving one step period
`include "stepper_trapezoid_step_timer_defines.svh"
module stt_period
   import stt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  period_req_type req,
   output period_res_type res
);
   localparam logic [1:0] P_IDLE = 2'd0;
   localparam logic [1:0] P_SQRT = 2'd1;
   localparam logic [1:0] P_DIV  = 2'd2;

   logic [1:0]  st_ff;
   logic [4:0]  cnt_ff;
   logic [47:0] rad_ff;
   logic [25:0] rem_ff;
   logic [23:0] root_ff;
   logic [23:0] v_ff;
   logic [28:0] dvd_ff;
   logic [24:0] drem_ff;
   logic [28:0] q_ff;
   logic        done_ff;
   logic [15:0] period_ff;
   logic        sat_ff;

   logic [27:0] rem_in;
   logic [27:0] trial;
   logic [25:0] rem_step;
   logic [23:0] root_in;
   logic [25:0] drem_next;
   logic [24:0] drem_in;
   logic [28:0] q_in;

   always_comb begin
      rem_in = {rem_ff, rad_ff[47:46]};
      trial = {2'b00, root_ff, 2'b01};
      if (rem_in >= trial) begin
         rem_step = 26'(rem_in - trial);
         root_in = {root_ff[22:0], 1'b1};
      end else begin
         rem_step = rem_in[25:0];
         root_in = {root_ff[22:0], 1'b0};
      end
      drem_next = {drem_ff, dvd_ff[28]};
      if (drem_next >= {2'b00, v_ff}) begin
         drem_in = 25'(drem_next - {2'b00, v_ff});
         q_in = {q_ff[27:0], 1'b1};
      end else begin
         drem_in = drem_next[24:0];
         q_in = {q_ff[27:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= P_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (st_ff == P_DIV) && (cnt_ff == 5'd0);
         case (st_ff)
            P_IDLE: begin
               if (req.start) begin
                  if (req.use_sqrt) begin
                     rad_ff <= req.sq;
                     rem_ff <= '0;
                     root_ff <= '0;
                     cnt_ff <= 5'd23;
                     st_ff <= P_SQRT;
                  end else begin
                     v_ff <= req.speed;
                     dvd_ff <= TIMER_DIVIDEND;
                     drem_ff <= '0;
                     q_ff <= '0;
                     cnt_ff <= 5'd28;
                     st_ff <= P_DIV;
                  end
               end
            end
            P_SQRT: begin
               rad_ff <= {rad_ff[45:0], 2'b00};
               rem_ff <= rem_step;
               root_ff <= root_in;
               if (cnt_ff == 5'd0) begin
                  v_ff <= root_in;
                  dvd_ff <= TIMER_DIVIDEND;
                  drem_ff <= '0;
                  q_ff <= '0;
                  cnt_ff <= 5'd28;
                  st_ff <= P_DIV;
               end else begin
                  cnt_ff <= cnt_ff - 5'd1;
               end
            end
            P_DIV: begin
               dvd_ff <= {dvd_ff[27:0], 1'b0};
               drem_ff <= drem_in;
               q_ff <= q_in;
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  if (v_ff == '0 || q_in[28:16] != '0) begin
                     period_ff <= PERIOD_MAX;
                     sat_ff <= 1'b1;
                  end else begin
                     period_ff <= q_in[15:0];
                     sat_ff <= 1'b0;
                  end
                  st_ff <= P_IDLE;
               end
            end
            default: st_ff <= P_IDLE;
         endcase
      end
   end

   assign res.done = done_ff;
   assign res.period = period_ff;
   assign res.sat = sat_ff;

   `STT_ASSERT_IMP(a_start_idle, clock, reset, req.start, st_ff == P_IDLE)
   `STT_ASSERT_NEXT(a_start_runs, clock, reset, req.start, st_ff != P_IDLE)
   `STT_ASSERT_IMP(a_done_idle, clock, reset, done_ff, st_ff == P_IDLE)
endmodule

/* src/stepper_trapezoid_step_timer.sv */
// top level of the trapezoidal stepper step timer
// Each req beat (tdata bit 0 = restart) yields one rsp beat with the period of the
// next step. A ramp step runs a square root and then a division in a
// shared unit; a restart adds a division for the cruise period; a mirrored
// step reads the 4096-entry ramp memory, whose read data is registered.
// The ramp memory needs no clearing; only entries written in the current move are read.
`include "stepper_trapezoid_step_timer_defines.svh"
module stepper_trapezoid_step_timer
   import stt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // period_ticks, step_dir, step_index, phase
   output logic [1:0]  rsp_tuser,   // saturated, beyond_end
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PREP   = 3'd1;
   localparam logic [2:0] S_CDIV   = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_RAMP   = 3'd4;
   localparam logic [2:0] S_ONE    = 3'd5;
   localparam logic [2:0] S_MEMRD  = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   logic [2:0]  state_ff;
   logic        restart_ff;
   logic [13:0] steps_ff;
   logic [23:0] init_speed_ff;
   logic [23:0] final_speed_ff;
   logic [31:0] accel_ff;
   logic        rotation_ff;
   logic [47:0] speed_sq_ff;
   logic [47:0] fsq_ff;
   logic [13:0] step_ctr_ff;
   logic [12:0] ramp_len_ff;
   logic        ramp_done_ff;
   logic [15:0] cruise_ff;
   logic [15:0] res_period_ff;
   logic        res_sat_ff;
   logic [1:0]  res_phase_ff;
   logic [12:0] res_index_ff;
   logic        res_last_ff;
   logic        res_beyond_ff;
   logic        rsp_tvalid_ff;
   logic [31:0] rsp_tdata_ff;
   logic [1:0]  rsp_tuser_ff;
   logic        rsp_tlast_ff;
   logic [15:0] ram [0:4095];
   logic [15:0] rd_data_ff;

   logic [13:0] n;
   logic [13:0] h;
   logic [13:0] j;
   logic        beyond;
   logic        first_half;
   logic        middle;
   logic        ramp_go;
   logic        mirror_hit;
   logic        mem_rd;
   logic [48:0] sum;
   logic [47:0] sq_in;
   period_req_type preq;
   period_res_type pres;

   stt_period u_period (
      .clock (clock),
      .reset (reset),
      .req   (preq),
      .res   (pres)
   );

   always_comb begin
      n = (steps_ff > MAX_STEPS) ? MAX_STEPS : steps_ff;
      h = {1'b0, n[13:1]};
      beyond = step_ctr_ff >= n;
      first_half = step_ctr_ff < h;
      middle = n[0] && (step_ctr_ff == h);
      j = middle ? 14'(h - 14'd1) : 14'(n - 14'd1 - step_ctr_ff);
      ramp_go = !ramp_done_ff && (step_ctr_ff == {1'b0, ramp_len_ff})
         && (step_ctr_ff < RAMP_DEPTH);
      mirror_hit = (j < {1'b0, ramp_len_ff}) && (j < RAMP_DEPTH);
      mem_rd = (state_ff == S_DECIDE) && !beyond && !first_half && (n != 14'd1)
         && mirror_hit;
      sum = {1'b0, speed_sq_ff} + {8'b0, accel_ff, 9'b0};
      sq_in = sum[48] ? '1 : sum[47:0];
      preq.start = ((state_ff == S_PREP) && restart_ff)
         || ((state_ff == S_DECIDE) && !beyond && first_half && ramp_go)
         || ((state_ff == S_DECIDE) && !beyond && !first_half && (n == 14'd1));
      preq.use_sqrt = (state_ff == S_DECIDE) && first_half;
      preq.sq = speed_sq_ff;
      preq.speed = (state_ff == S_PREP) ? final_speed_ff : init_speed_ff;
   end

   always_ff @(posedge clock) begin
      fsq_ff <= final_speed_ff * final_speed_ff;
      if (mem_rd) begin
         rd_data_ff <= ram[j[RAMP_AW-1:0]];
      end
      if (state_ff == S_RAMP && pres.done) begin
         ram[res_index_ff[RAMP_AW-1:0]] <= pres.period;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         steps_ff <= '0;
         init_speed_ff <= 24'd25600;
         final_speed_ff <= 24'd256000;
         accel_ff <= 32'd256000;
         rotation_ff <= 1'b0;
         speed_sq_ff <= '0;
         step_ctr_ff <= '0;
         ramp_len_ff <= '0;
         ramp_done_ff <= 1'b0;
         cruise_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_STEP_COUNT:  steps_ff <= csr_data[13:0];
               CSR_INIT_SPEED:  init_speed_ff <= csr_data[23:0];
               CSR_FINAL_SPEED: final_speed_ff <= csr_data[23:0];
               CSR_ACCEL:       accel_ff <= csr_data;
               CSR_ROTATION:    rotation_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (rsp_tvalid_ff && rsp_tready && state_ff != S_OUT) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  restart_ff <= req_tdata[0];
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               if (restart_ff) begin
                  speed_sq_ff <= init_speed_ff * init_speed_ff;
                  step_ctr_ff <= '0;
                  ramp_len_ff <= '0;
                  ramp_done_ff <= 1'b0;
                  state_ff <= S_CDIV;
               end else begin
                  state_ff <= S_DECIDE;
               end
            end
            S_CDIV: begin
               if (pres.done) begin
                  cruise_ff <= pres.period;
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               res_beyond_ff <= beyond;
               if (beyond) begin
                  res_index_ff <= '0;
                  res_last_ff <= 1'b0;
                  res_period_ff <= '0;
                  res_sat_ff <= 1'b0;
                  res_phase_ff <= PH_ACCEL;
                  state_ff <= S_OUT;
               end else begin
                  res_index_ff <= step_ctr_ff[12:0];
                  res_last_ff <= step_ctr_ff == 14'(n - 14'd1);
                  res_period_ff <= cruise_ff;
                  res_sat_ff <= cruise_ff == PERIOD_MAX;
                  res_phase_ff <= (!first_half && n != 14'd1 && mirror_hit && !middle)
                     ? PH_DECEL : PH_CRUISE;
                  step_ctr_ff <= step_ctr_ff + 14'd1;
                  if (first_half) begin
                     state_ff <= ramp_go ? S_RAMP : S_OUT;
                  end else if (n == 14'd1) begin
                     state_ff <= S_ONE;
                  end else if (mirror_hit) begin
                     state_ff <= S_MEMRD;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end
            end
            S_RAMP: begin
               if (pres.done) begin
                  res_period_ff <= pres.period;
                  res_sat_ff <= pres.sat;
                  res_phase_ff <= PH_ACCEL;
                  ramp_len_ff <= 13'(res_index_ff + 13'd1);
                  speed_sq_ff <= sq_in;
                  if (sq_in >= fsq_ff) begin
                     ramp_done_ff <= 1'b1;
                  end
                  state_ff <= S_OUT;
               end
            end
            S_ONE: begin
               if (pres.done) begin
                  res_period_ff <= pres.period;
                  res_sat_ff <= pres.sat;
                  res_phase_ff <= PH_ACCEL;
                  state_ff <= S_OUT;
               end
            end
            S_MEMRD: begin
               res_period_ff <= rd_data_ff;
               res_sat_ff <= rd_data_ff == PERIOD_MAX;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff <= {res_phase_ff, res_index_ff,
                     rotation_ff & !res_beyond_ff, res_period_ff};
                  rsp_tuser_ff <= {res_beyond_ff, res_sat_ff};
                  rsp_tlast_ff <= res_last_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;
   assign rsp_tlast = rsp_tlast_ff;

   `STT_ASSERT_IMP(a_ramp_len, clock, reset, 1'b1, {1'b0, ramp_len_ff} <= RAMP_DEPTH)
   `STT_ASSERT_IMP(a_beyond_zero, clock, reset, rsp_tvalid_ff && rsp_tuser_ff[1],
      rsp_tdata_ff == '0 && !rsp_tlast_ff)
   `STT_ASSERT_IMP(a_ctr_bound, clock, reset, state_ff == S_IDLE, step_ctr_ff <= MAX_STEPS)
endmodule
